// ----- hdl/sfcs_pkg.sv -----
`default_nettype none
package sfcs_pkg;
    localparam int unsigned PAGE_BYTES = 256;
    localparam int unsigned PAGE_W     = $clog2(PAGE_BYTES);
    localparam int unsigned PLEFT_W    = PAGE_W + 1;
    localparam int unsigned MAX_RES    = 9;
    localparam int unsigned CNT_W      = 4;

    // phases
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_PROG = 4'd1;
    localparam logic [3:0] PH_POLL = 4'd2;
    localparam logic [3:0] PH_READ = 4'd3;
    localparam logic [3:0] PH_ID   = 4'd4;

    // request types
    localparam logic [2:0] RQ_BUS    = 3'd0;
    localparam logic [2:0] RQ_PROG   = 3'd1;
    localparam logic [2:0] RQ_DATA   = 3'd2;
    localparam logic [2:0] RQ_READ   = 3'd3;
    localparam logic [2:0] RQ_SECTOR = 3'd4;
    localparam logic [2:0] RQ_BLOCK  = 3'd5;
    localparam logic [2:0] RQ_CHIP   = 3'd6;
    localparam logic [2:0] RQ_IDENT  = 3'd7;

    // result kinds
    localparam logic [2:0] K_SEND   = 3'd0;
    localparam logic [2:0] K_DESEL  = 3'd1;
    localparam logic [2:0] K_READ   = 3'd2;
    localparam logic [2:0] K_ID     = 3'd3;
    localparam logic [2:0] K_DONE   = 3'd4;
    localparam logic [2:0] K_REFUSE = 3'd5;

    // register indexes
    localparam logic [2:0] R_WREN  = 3'd0;
    localparam logic [2:0] R_RDSR  = 3'd1;
    localparam logic [2:0] R_PP    = 3'd2;
    localparam logic [2:0] R_READ  = 3'd3;
    localparam logic [2:0] R_RDID  = 3'd4;
    localparam logic [2:0] R_SE    = 3'd5;
    localparam logic [2:0] R_BE    = 3'd6;
    localparam logic [2:0] R_CE    = 3'd7;

    localparam logic [7:0] DUMMY = 8'hFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [23:0] id_value;
    } res_t;
endpackage
`default_nettype wire

// ----- hdl/spi_flash_command_sequencer.sv -----
// Channel  | Dir | Payload
// s_axis   | in  | tdata {data_byte, length, address}, tuser req_type
// m_axis   | out | tdata {id_value, byte_value}, tuser kind, tlast last
// cfg      | in  | cfg_we, cfg_index[2:0], cfg_wdata[7:0]
// An input beat is turned combinationally into a frame of up to nine result
// beats; the first beat is offered in the cycle after the accept and the frame
// drains one beat per cycle while m_tready is high. The next input beat is
// taken on the edge that pops the last one.
// Reset (aresetn low, synchronous) returns the phase to idle and the
// opcode registers to their defaults. m_tready low holds the frame.
`default_nettype none
module spi_flash_command_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address[23:0], length[39:24], data_byte[47:40]
    input  wire logic [47:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // byte_value[7:0], id_value[31:8]
    output logic [31:0]      m_tdata,
    // kind[2:0]
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    localparam int unsigned PW = sfcs_pkg::PLEFT_W;
    localparam int unsigned CW = sfcs_pkg::CNT_W;

    logic [7:0] regs_reg [8];
    logic [3:0]  phase_reg, phase_next;
    logic [23:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [PW-1:0] pleft_reg, pleft_next;
    logic [23:0] idacc_reg, idacc_next;
    logic [1:0]  idcnt_reg, idcnt_next;
    logic        after_reg, after_next;

    sfcs_pkg::res_t frame_reg [sfcs_pkg::MAX_RES];
    sfcs_pkg::res_t frame_next [sfcs_pkg::MAX_RES];
    logic [CW-1:0] cnt_reg, cnt_next, pos_reg;

    logic [2:0]  req;
    logic [23:0] s_addr;
    logic [15:0] s_len;
    logic [7:0]  s_db;
    logic        take, pop;

    assign req    = s_tuser;
    assign s_addr = s_tdata[23:0];
    assign s_len  = s_tdata[39:24];
    assign s_db   = s_tdata[47:40];

    // frame drains fully before a new beat; last beat pop frees the slot
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (pop && (pos_reg + CW'(1) == cnt_reg));
    assign take     = s_tvalid && s_tready;

    assign m_tuser = frame_reg[pos_reg].kind;
    assign m_tdata = {frame_reg[pos_reg].id_value, frame_reg[pos_reg].byte_value};
    assign m_tlast = (pos_reg + CW'(1) == cnt_reg);

    // opcode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[sfcs_pkg::R_WREN] <= 8'h06; regs_reg[sfcs_pkg::R_RDSR] <= 8'h05;
            regs_reg[sfcs_pkg::R_PP]   <= 8'h02; regs_reg[sfcs_pkg::R_READ] <= 8'h03;
            regs_reg[sfcs_pkg::R_RDID] <= 8'h9F; regs_reg[sfcs_pkg::R_SE]   <= 8'h20;
            regs_reg[sfcs_pkg::R_BE]   <= 8'hD8; regs_reg[sfcs_pkg::R_CE]   <= 8'hC7;
        end else if (cfg_we) begin
            regs_reg[cfg_index] <= cfg_wdata;
        end
    end

    // build one frame from the accepted beat
    always_comb begin
        logic [CW-1:0] n;
        logic [23:0] pa;
        logic [PW-1:0] room;
        logic [15:0] rdec;
        logic [PW-1:0] pdec;
        logic [23:0] acc;
        logic [1:0]  ic;
        n = '0;
        pa = '0;
        room = '0;
        rdec = '0;
        pdec = '0;
        acc = '0;
        ic = '0;
        phase_next = phase_reg;
        addr_next = addr_reg;
        rem_next = rem_reg;
        pleft_next = pleft_reg;
        idacc_next = idacc_reg;
        idcnt_next = idcnt_reg;
        after_next = after_reg;
        for (int i = 0; i < sfcs_pkg::MAX_RES; i++) begin
            frame_next[i] = '{kind: sfcs_pkg::K_SEND, byte_value: 8'd0, id_value: 24'd0};
        end

        unique case (phase_reg)
            sfcs_pkg::PH_IDLE: begin
                if (req == sfcs_pkg::RQ_PROG && s_len == 16'd0) begin
                    frame_next[0].kind = sfcs_pkg::K_DONE; n = 4'd1;
                end else if (req == sfcs_pkg::RQ_PROG) begin
                    pa = s_addr;
                    room = PW'(sfcs_pkg::PAGE_BYTES) - PW'(s_addr[sfcs_pkg::PAGE_W-1:0]);
                    pleft_next = ({{(16-PW){1'b0}}, room} < s_len) ? room : PW'(s_len);
                    addr_next = s_addr; rem_next = s_len;
                    frame_next[0].byte_value = regs_reg[sfcs_pkg::R_WREN];
                    frame_next[1].kind = sfcs_pkg::K_DESEL;
                    frame_next[2].byte_value = regs_reg[sfcs_pkg::R_PP];
                    frame_next[3].byte_value = pa[23:16];
                    frame_next[4].byte_value = pa[15:8];
                    frame_next[5].byte_value = pa[7:0];
                    n = 4'd6; phase_next = sfcs_pkg::PH_PROG;
                end else if (req == sfcs_pkg::RQ_READ) begin
                    frame_next[0].byte_value = regs_reg[sfcs_pkg::R_READ];
                    frame_next[1].byte_value = s_addr[23:16];
                    frame_next[2].byte_value = s_addr[15:8];
                    frame_next[3].byte_value = s_addr[7:0];
                    addr_next = s_addr; rem_next = s_len;
                    if (s_len == 16'd0) begin
                        frame_next[4].kind = sfcs_pkg::K_DESEL;
                        frame_next[5].kind = sfcs_pkg::K_DONE;
                        n = 4'd6;
                    end else begin
                        frame_next[4].byte_value = sfcs_pkg::DUMMY;
                        n = 4'd5; phase_next = sfcs_pkg::PH_READ;
                    end
                end else if (req == sfcs_pkg::RQ_SECTOR || req == sfcs_pkg::RQ_BLOCK) begin
                    frame_next[0].byte_value = regs_reg[sfcs_pkg::R_WREN];
                    frame_next[1].kind = sfcs_pkg::K_DESEL;
                    frame_next[2].byte_value = (req == sfcs_pkg::RQ_SECTOR) ?
                        regs_reg[sfcs_pkg::R_SE] : regs_reg[sfcs_pkg::R_BE];
                    frame_next[3].byte_value = s_addr[23:16];
                    frame_next[4].byte_value = s_addr[15:8];
                    frame_next[5].byte_value = s_addr[7:0];
                    frame_next[6].kind = sfcs_pkg::K_DESEL;
                    frame_next[7].byte_value = regs_reg[sfcs_pkg::R_RDSR];
                    frame_next[8].byte_value = sfcs_pkg::DUMMY;
                    n = 4'd9; after_next = 1'b0; phase_next = sfcs_pkg::PH_POLL;
                end else if (req == sfcs_pkg::RQ_CHIP) begin
                    frame_next[0].byte_value = regs_reg[sfcs_pkg::R_WREN];
                    frame_next[1].kind = sfcs_pkg::K_DESEL;
                    frame_next[2].byte_value = regs_reg[sfcs_pkg::R_CE];
                    frame_next[3].kind = sfcs_pkg::K_DESEL;
                    frame_next[4].byte_value = regs_reg[sfcs_pkg::R_RDSR];
                    frame_next[5].byte_value = sfcs_pkg::DUMMY;
                    n = 4'd6; after_next = 1'b0; phase_next = sfcs_pkg::PH_POLL;
                end else if (req == sfcs_pkg::RQ_IDENT) begin
                    idacc_next = '0; idcnt_next = '0;
                    frame_next[0].byte_value = regs_reg[sfcs_pkg::R_RDID];
                    frame_next[1].byte_value = sfcs_pkg::DUMMY;
                    n = 4'd2; phase_next = sfcs_pkg::PH_ID;
                end else begin
                    frame_next[0].kind = sfcs_pkg::K_REFUSE; n = 4'd1;
                end
            end
            sfcs_pkg::PH_PROG: begin
                if (req != sfcs_pkg::RQ_DATA) begin
                    frame_next[0].kind = sfcs_pkg::K_REFUSE; n = 4'd1;
                end else begin
                    frame_next[0].byte_value = s_db;
                    addr_next = addr_reg + 24'd1;
                    rdec = (rem_reg != 16'd0) ? rem_reg - 16'd1 : rem_reg;
                    pdec = (pleft_reg != '0) ? pleft_reg - PW'(1) : pleft_reg;
                    rem_next = rdec; pleft_next = pdec;
                    n = 4'd1;
                    if (pdec == '0) begin
                        frame_next[1].kind = sfcs_pkg::K_DESEL;
                        frame_next[2].byte_value = regs_reg[sfcs_pkg::R_RDSR];
                        frame_next[3].byte_value = sfcs_pkg::DUMMY;
                        n = 4'd4; after_next = 1'b1; phase_next = sfcs_pkg::PH_POLL;
                    end
                end
            end
            sfcs_pkg::PH_POLL: begin
                if (req != sfcs_pkg::RQ_BUS) begin
                    frame_next[0].kind = sfcs_pkg::K_REFUSE; n = 4'd1;
                end else if (s_db[0]) begin
                    frame_next[0].byte_value = sfcs_pkg::DUMMY; n = 4'd1;
                end else if (after_reg && rem_reg != 16'd0) begin
                    // next page
                    room = PW'(sfcs_pkg::PAGE_BYTES) -
                           PW'(addr_reg[sfcs_pkg::PAGE_W-1:0]);
                    pleft_next = ({{(16-PW){1'b0}}, room} < rem_reg) ? room : PW'(rem_reg);
                    frame_next[0].kind = sfcs_pkg::K_DESEL;
                    frame_next[1].byte_value = regs_reg[sfcs_pkg::R_WREN];
                    frame_next[2].kind = sfcs_pkg::K_DESEL;
                    frame_next[3].byte_value = regs_reg[sfcs_pkg::R_PP];
                    frame_next[4].byte_value = addr_reg[23:16];
                    frame_next[5].byte_value = addr_reg[15:8];
                    frame_next[6].byte_value = addr_reg[7:0];
                    n = 4'd7; phase_next = sfcs_pkg::PH_PROG;
                end else begin
                    frame_next[0].kind = sfcs_pkg::K_DESEL;
                    frame_next[1].kind = sfcs_pkg::K_DONE;
                    n = 4'd2; after_next = 1'b0; phase_next = sfcs_pkg::PH_IDLE;
                end
            end
            sfcs_pkg::PH_READ: begin
                if (req != sfcs_pkg::RQ_BUS) begin
                    frame_next[0].kind = sfcs_pkg::K_REFUSE; n = 4'd1;
                end else begin
                    frame_next[0].kind = sfcs_pkg::K_READ;
                    frame_next[0].byte_value = s_db;
                    addr_next = addr_reg + 24'd1;
                    rdec = (rem_reg != 16'd0) ? rem_reg - 16'd1 : rem_reg;
                    rem_next = rdec;
                    if (rdec != 16'd0) begin
                        frame_next[1].byte_value = sfcs_pkg::DUMMY; n = 4'd2;
                    end else begin
                        frame_next[1].kind = sfcs_pkg::K_DESEL;
                        frame_next[2].kind = sfcs_pkg::K_DONE;
                        n = 4'd3; phase_next = sfcs_pkg::PH_IDLE;
                    end
                end
            end
            sfcs_pkg::PH_ID: begin
                if (req != sfcs_pkg::RQ_BUS) begin
                    frame_next[0].kind = sfcs_pkg::K_REFUSE; n = 4'd1;
                end else begin
                    acc = {idacc_reg[15:0], s_db};
                    ic = idcnt_reg + 2'd1;
                    idacc_next = acc; idcnt_next = ic;
                    if (ic != 2'd3) begin
                        frame_next[0].byte_value = sfcs_pkg::DUMMY; n = 4'd1;
                    end else begin
                        frame_next[0].kind = sfcs_pkg::K_DESEL;
                        frame_next[1].kind = sfcs_pkg::K_ID;
                        frame_next[1].id_value = acc;
                        idcnt_next = '0;
                        n = 4'd2; phase_next = sfcs_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                frame_next[0].kind = sfcs_pkg::K_REFUSE; n = 4'd1;
                phase_next = sfcs_pkg::PH_IDLE;
            end
        endcase
        cnt_next = n;
    end

    // state and frame registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfcs_pkg::PH_IDLE;
            addr_reg <= '0; rem_reg <= '0; pleft_reg <= '0;
            idacc_reg <= '0; idcnt_reg <= '0; after_reg <= 1'b0;
            cnt_reg <= '0; pos_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            addr_reg <= addr_next; rem_reg <= rem_next; pleft_reg <= pleft_next;
            idacc_reg <= idacc_next; idcnt_reg <= idcnt_next; after_reg <= after_next;
            cnt_reg <= cnt_next; pos_reg <= '0;
        end else if (pop) begin
            if (m_tlast) begin
                cnt_reg <= '0; pos_reg <= '0;
            end else begin
                pos_reg <= pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < sfcs_pkg::MAX_RES; i++) frame_reg[i] <= frame_next[i];
        end
    end

    // checks
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pos_reg < cnt_reg) else $error("beat index past frame");
    a_frame_size: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(sfcs_pkg::MAX_RES)) else $error("frame too long");
    a_take_makes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_tvalid && pos_reg == '0) else $error("accepted beat gave no frame");
    a_idle_poll_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == sfcs_pkg::PH_IDLE |-> !after_reg) else $error("stale poll flag");
endmodule
`default_nettype wire

// ----- dv/spi_flash_command_sequencer_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module spi_flash_command_sequencer_tb;

    localparam int unsigned RUN_LIMIT = 2_000_000;
    localparam int unsigned N_RANDOM  = 75;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [23:0] id_value;
        logic        last;
    } flash_beat_t;

    typedef struct {
        logic [2:0]  req;
        logic [23:0] addr;
        logic [15:0] len;
        logic [7:0]  data;
        logic        has_known; // first expected beat typed in by hand
        logic [2:0]  known_kind;
    } host_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    spi_flash_command_sequencer u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_we, .cfg_index, .cfg_wdata
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sequencer shadow state
    logic [7:0]  opc [8];
    logic [3:0]  seq_phase;
    logic [23:0] seq_addr;
    logic [15:0] seq_remain;
    logic [8:0]  seq_page_left;
    logic [23:0] seq_id_acc;
    logic [1:0]  seq_id_cnt;
    logic        seq_resume_prog;

    flash_beat_t frame_q [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int unsigned status_polls = 0;  // busy polls left in the current wait

    function automatic void push_beat(logic [2:0] k, logic [7:0] b, logic [23:0] id);
        flash_beat_t e;
        e.kind = k;
        e.byte_value = b;
        e.id_value = id;
        e.last = 1'b0;
        frame_q.push_back(e);
    endfunction

    function automatic void push_addr(logic [23:0] a);
        push_beat(sfcs_pkg::K_SEND, a[23:16], '0);
        push_beat(sfcs_pkg::K_SEND, a[15:8], '0);
        push_beat(sfcs_pkg::K_SEND, a[7:0], '0);
    endfunction

    function automatic void begin_status_poll(logic resume);
        push_beat(sfcs_pkg::K_DESEL, '0, '0);
        push_beat(sfcs_pkg::K_SEND, opc[sfcs_pkg::R_RDSR], '0);
        push_beat(sfcs_pkg::K_SEND, sfcs_pkg::DUMMY, '0);
        seq_resume_prog = resume;
        seq_phase = sfcs_pkg::PH_POLL;
    endfunction

    function automatic void begin_page();
        logic [9:0] room;
        room = 10'(sfcs_pkg::PAGE_BYTES) - 10'(seq_addr % sfcs_pkg::PAGE_BYTES);
        seq_page_left = (room < seq_remain) ? room[8:0] : seq_remain[8:0];
        push_beat(sfcs_pkg::K_SEND, opc[sfcs_pkg::R_WREN], '0);
        push_beat(sfcs_pkg::K_DESEL, '0, '0);
        push_beat(sfcs_pkg::K_SEND, opc[sfcs_pkg::R_PP], '0);
        push_addr(seq_addr);
        seq_phase = sfcs_pkg::PH_PROG;
    endfunction

    function automatic void begin_erase(logic [7:0] op, bit with_addr, logic [23:0] a);
        push_beat(sfcs_pkg::K_SEND, opc[sfcs_pkg::R_WREN], '0);
        push_beat(sfcs_pkg::K_DESEL, '0, '0);
        push_beat(sfcs_pkg::K_SEND, op, '0);
        if (with_addr) push_addr(a);
        begin_status_poll(1'b0);
    endfunction

    function automatic void seq_reset();
        opc[sfcs_pkg::R_WREN] = 8'h06; opc[sfcs_pkg::R_RDSR] = 8'h05;
        opc[sfcs_pkg::R_PP] = 8'h02;   opc[sfcs_pkg::R_READ] = 8'h03;
        opc[sfcs_pkg::R_RDID] = 8'h9F; opc[sfcs_pkg::R_SE] = 8'h20;
        opc[sfcs_pkg::R_BE] = 8'hD8;   opc[sfcs_pkg::R_CE] = 8'hC7;
        seq_phase = sfcs_pkg::PH_IDLE; seq_addr = '0; seq_remain = '0;
        seq_page_left = '0; seq_id_acc = '0; seq_id_cnt = '0;
        seq_resume_prog = 1'b0;
    endfunction

    // expected frame for one accepted host request
    function automatic void predict_frame(host_req_t r);
        int unsigned base;
        base = frame_q.size();
        case (seq_phase)
            sfcs_pkg::PH_IDLE: begin
                case (r.req)
                    sfcs_pkg::RQ_PROG: begin
                        if (r.len == 0) push_beat(sfcs_pkg::K_DONE, '0, '0);
                        else begin
                            seq_addr = r.addr;
                            seq_remain = r.len;
                            begin_page();
                        end
                    end
                    sfcs_pkg::RQ_READ: begin
                        push_beat(sfcs_pkg::K_SEND, opc[sfcs_pkg::R_READ], '0);
                        push_addr(r.addr);
                        seq_addr = r.addr;
                        seq_remain = r.len;
                        if (r.len == 0) begin
                            push_beat(sfcs_pkg::K_DESEL, '0, '0);
                            push_beat(sfcs_pkg::K_DONE, '0, '0);
                        end else begin
                            push_beat(sfcs_pkg::K_SEND, sfcs_pkg::DUMMY, '0);
                            seq_phase = sfcs_pkg::PH_READ;
                        end
                    end
                    sfcs_pkg::RQ_SECTOR: begin_erase(opc[sfcs_pkg::R_SE], 1, r.addr);
                    sfcs_pkg::RQ_BLOCK:  begin_erase(opc[sfcs_pkg::R_BE], 1, r.addr);
                    sfcs_pkg::RQ_CHIP:   begin_erase(opc[sfcs_pkg::R_CE], 0, '0);
                    sfcs_pkg::RQ_IDENT: begin
                        seq_id_acc = '0;
                        seq_id_cnt = '0;
                        push_beat(sfcs_pkg::K_SEND, opc[sfcs_pkg::R_RDID], '0);
                        push_beat(sfcs_pkg::K_SEND, sfcs_pkg::DUMMY, '0);
                        seq_phase = sfcs_pkg::PH_ID;
                    end
                    default: push_beat(sfcs_pkg::K_REFUSE, '0, '0);
                endcase
            end
            sfcs_pkg::PH_PROG: begin
                if (r.req != sfcs_pkg::RQ_DATA) push_beat(sfcs_pkg::K_REFUSE, '0, '0);
                else begin
                    push_beat(sfcs_pkg::K_SEND, r.data, '0);
                    seq_addr = seq_addr + 24'd1;
                    if (seq_remain > 0) seq_remain = seq_remain - 16'd1;
                    if (seq_page_left > 0) seq_page_left = seq_page_left - 9'd1;
                    if (seq_page_left == 0) begin_status_poll(1'b1);
                end
            end
            sfcs_pkg::PH_POLL: begin
                if (r.req != sfcs_pkg::RQ_BUS) push_beat(sfcs_pkg::K_REFUSE, '0, '0);
                else if (r.data[0]) push_beat(sfcs_pkg::K_SEND, sfcs_pkg::DUMMY, '0);
                else begin
                    push_beat(sfcs_pkg::K_DESEL, '0, '0);
                    if (seq_resume_prog && seq_remain > 0) begin_page();
                    else begin
                        push_beat(sfcs_pkg::K_DONE, '0, '0);
                        seq_resume_prog = 1'b0;
                        seq_phase = sfcs_pkg::PH_IDLE;
                    end
                end
            end
            sfcs_pkg::PH_READ: begin
                if (r.req != sfcs_pkg::RQ_BUS) push_beat(sfcs_pkg::K_REFUSE, '0, '0);
                else begin
                    push_beat(sfcs_pkg::K_READ, r.data, '0);
                    seq_addr = seq_addr + 24'd1;
                    if (seq_remain > 0) seq_remain = seq_remain - 16'd1;
                    if (seq_remain > 0) push_beat(sfcs_pkg::K_SEND, sfcs_pkg::DUMMY, '0);
                    else begin
                        push_beat(sfcs_pkg::K_DESEL, '0, '0);
                        push_beat(sfcs_pkg::K_DONE, '0, '0);
                        seq_phase = sfcs_pkg::PH_IDLE;
                    end
                end
            end
            sfcs_pkg::PH_ID: begin
                if (r.req != sfcs_pkg::RQ_BUS) push_beat(sfcs_pkg::K_REFUSE, '0, '0);
                else begin
                    seq_id_acc = {seq_id_acc[15:0], r.data};
                    seq_id_cnt = seq_id_cnt + 2'd1;
                    if (seq_id_cnt < 3) push_beat(sfcs_pkg::K_SEND, sfcs_pkg::DUMMY, '0);
                    else begin
                        push_beat(sfcs_pkg::K_DESEL, '0, '0);
                        push_beat(sfcs_pkg::K_ID, '0, seq_id_acc);
                        seq_id_cnt = '0;
                        seq_phase = sfcs_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                seq_phase = sfcs_pkg::PH_IDLE;
                push_beat(sfcs_pkg::K_REFUSE, '0, '0);
            end
        endcase
        if (r.has_known && frame_q[base].kind != r.known_kind) begin
            $display("%0t table row: typed kind %0d, predicted %0d", $realtime,
                     r.known_kind, frame_q[base].kind);
            errors++;
        end
        if (frame_q.size() > base) frame_q[frame_q.size() - 1].last = 1'b1;
    endfunction

    // timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall, optional long hold-off, compare
    always @(posedge aclk) begin
        flash_beat_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.byte_value = m_tdata[7:0];
            got.id_value = m_tdata[31:8];
            got.last = m_tlast;
            if (frame_q.size() == 0) begin
                $display("%0t unexpected beat: got %h", $realtime, got);
                errors++;
            end else begin
                want = frame_q.pop_front();
                if (got.kind != want.kind || got.byte_value != want.byte_value ||
                    got.id_value != want.id_value || got.last != want.last) begin
                    $display("%0t beat mismatch: expected k%0d b%h id%h l%0d, %s",
                             $realtime, want.kind, want.byte_value, want.id_value,
                             want.last, "got below");
                    $display("%0t   got k%0d b%h id%h l%0d", $realtime,
                             got.kind, got.byte_value, got.id_value, got.last);
                    errors++;
                end
            end
        end
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted here
    task automatic receiver_hold(int unsigned n);
        hold_off = 1'b1;
        repeat (n) @(posedge aclk);
        hold_off = 1'b0;
    endtask

    task automatic send_req(host_req_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.req;
        s_tdata <= {r.data, r.len, r.addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_opcode(logic [2:0] idx, logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        opc[idx] = v;
    endtask

    function automatic host_req_t mk(logic [2:0] q, logic [23:0] a, logic [15:0] l,
                                     logic [7:0] d);
        host_req_t r;
        r.req = q; r.addr = a; r.len = l; r.data = d;
        r.has_known = 1'b0; r.known_kind = sfcs_pkg::K_SEND;
        return r;
    endfunction

    function automatic host_req_t mk_known(logic [2:0] q, logic [23:0] a, logic [15:0] l,
                                           logic [7:0] d, logic [2:0] k);
        host_req_t r;
        r = mk(q, a, l, d);
        r.has_known = 1'b1;
        r.known_kind = k;
        return r;
    endfunction

    // request or bus answer that fits the current phase, mostly well formed
    function automatic host_req_t next_req();
        logic [7:0] d;
        d = 8'($urandom);
        if ($urandom_range(99) < 6)
            return mk(3'($urandom), 24'($urandom), 16'($urandom), d);
        case (seq_phase)
            sfcs_pkg::PH_PROG: return mk(sfcs_pkg::RQ_DATA, 24'($urandom), 16'($urandom), d);
            sfcs_pkg::PH_POLL: begin
                if (status_polls > 0) begin
                    status_polls--;
                    d[0] = 1'b1;
                end else d[0] = 1'b0;
                return mk(sfcs_pkg::RQ_BUS, 24'($urandom), 16'($urandom), d);
            end
            sfcs_pkg::PH_READ, sfcs_pkg::PH_ID:
                return mk(sfcs_pkg::RQ_BUS, 24'($urandom), 16'($urandom), d);
            default: begin
                status_polls = $urandom_range(3);
                case ($urandom_range(9))
                    0, 1, 2: return mk(sfcs_pkg::RQ_PROG, 24'($urandom),
                                       16'($urandom_range(0, 20)), d);
                    3: return mk(sfcs_pkg::RQ_PROG,
                                 {16'($urandom), 8'($urandom_range(240, 255))},
                                 16'($urandom_range(1, 40)), d);
                    4, 5: return mk(sfcs_pkg::RQ_READ, 24'($urandom),
                                    16'($urandom_range(0, 12)), d);
                    6: return mk(sfcs_pkg::RQ_SECTOR + 3'($urandom_range(2)), 24'($urandom),
                                 16'($urandom), d);
                    7: return mk(sfcs_pkg::RQ_IDENT, 24'($urandom), 16'($urandom), d);
                    default: return mk(3'($urandom), 24'($urandom), 16'($urandom), d);
                endcase
            end
        endcase
    endfunction

    host_req_t directed_rows [$];

    initial begin
        seq_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: refusals, every request, wraps and page edges
        directed_rows = '{
            mk_known(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h00, sfcs_pkg::K_REFUSE),
            mk_known(sfcs_pkg::RQ_DATA, 24'hFFFFFF, 16'hFFFF, 8'hFF, sfcs_pkg::K_REFUSE),
            mk_known(sfcs_pkg::RQ_PROG, 24'h123456, 16'h0, 8'h00, sfcs_pkg::K_DONE),
            mk_known(sfcs_pkg::RQ_READ, 24'hFFFFFF, 16'h0, 8'h00, sfcs_pkg::K_SEND),
            mk_known(sfcs_pkg::RQ_PROG, 24'hFFFFFE, 16'h3, 8'h00, sfcs_pkg::K_SEND),
            mk_known(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h11, sfcs_pkg::K_REFUSE),
            mk(sfcs_pkg::RQ_DATA, 24'h0, 16'h0, 8'hA5),
            mk(sfcs_pkg::RQ_DATA, 24'h0, 16'h0, 8'h5A),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h01),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'hFE),
            mk(sfcs_pkg::RQ_DATA, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_READ, 24'hFFFFFF, 16'h2, 8'h00),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'hFF),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_SECTOR, 24'hABCDEF, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_BLOCK, 24'h000000, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_CHIP, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_IDENT, 24'h0, 16'h0, 8'h00),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'hEF),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h40),
            mk(sfcs_pkg::RQ_BUS, 24'h0, 16'h0, 8'h18)
        };
        foreach (directed_rows[i]) send_req(directed_rows[i]);
        drain();

        // full page then one more byte (two pages, no trailing empty page)
        send_req(mk(sfcs_pkg::RQ_PROG, 24'h000100, 16'(sfcs_pkg::PAGE_BYTES + 1), 8'h00));
        for (int i = 0; i < sfcs_pkg::PAGE_BYTES; i++) send_req(next_req());
        while (seq_phase != sfcs_pkg::PH_IDLE) send_req(next_req());
        drain();

        // random phases across opcode settings and idle mixes
        for (int ph = 0; ph < 5; ph++) begin
            for (int i = 0; i < 8; i++)
                write_opcode(3'(i), (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom));
            cfg_we <= 1'b0;
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                3: begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                fork
                    receiver_hold(400);
                    for (int i = 0; i < 60; i++) send_req(next_req());
                join
            end
            for (int i = 0; i < N_RANDOM / 5; i++) send_req(next_req());
            while (seq_phase != sfcs_pkg::PH_IDLE) send_req(next_req());
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/sfcs_pkg.sv
hdl/spi_flash_command_sequencer.sv
dv/spi_flash_command_sequencer_tb.sv
